@@ src/cll_pkg.sv @@
package cll_pkg;

  localparam int POOL_CELLS = 16;
  localparam int CELL_W     = $clog2(POOL_CELLS);
  localparam int VAL_W      = 32;
  localparam int FUNC_W     = 2;
  localparam int POS_W      = 4;
  localparam int FC_W       = 4;
  localparam int STAT_W     = 2;
  // wide enough to hold a position or a cell index without aliasing
  localparam int PW         = (CELL_W > POS_W) ? CELL_W : POS_W;
  // walk step counter, holds POOL_CELLS itself
  localparam int CNT_W      = $clog2(POOL_CELLS + 1);

  typedef enum logic [FUNC_W-1:0] {
    F_INS  = 2'd0,
    F_DEL  = 2'd1,
    F_FIND = 2'd2,
    F_NOP  = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_BADPOS   = 2'd3
  } status_t;

  // shared read address for link and value arrays
  typedef enum logic [2:0] {
    A_ZERO = 3'd0,
    A_ONE  = 3'd1,
    A_CUR  = 3'd2,
    A_POS  = 3'd3,
    A_FREE = 3'd4
  } rd_sel_t;

  typedef enum logic [2:0] {
    W_PREV = 3'd0,
    W_CUR  = 3'd1,
    W_ZERO = 3'd2,
    W_POS  = 3'd3,
    W_FREE = 3'd4
  } wr_sel_t;

  typedef enum logic [1:0] {
    D_RL   = 2'd0,
    D_CUR  = 2'd1,
    D_FREE = 2'd2
  } wd_sel_t;

  typedef enum logic [1:0] {
    C_NONE = 2'd0,
    C_CUR  = 2'd1,
    C_FREE = 2'd2
  } cell_sel_t;

  typedef struct packed {
    logic      cap;        // capture request fields
    rd_sel_t   rd_sel;
    logic      walk_init;  // cur <= link read, prev <= header
    logic      walk_step;  // prev <= cur, cur <= link read
    logic      free_load;  // free <= link read
    logic      lw_en;
    wr_sel_t   lw_addr;
    wd_sel_t   lw_data;
    logic      vw_en;      // value write at the read address
    logic      vw_clear;
    logic      res_ld;
    status_t   res_status;
    cell_sel_t res_cell;
    logic      out_ld;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  pos_zero;
    logic  pos_one;
    logic  cur_zero;
    logic  cur_eq_pos;
    logic  val_match;
    logic  walk_over;
    logic  rl_low;     // link read is 0 or 1: no free cell
  } stat_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_WSTART = 10'b00_0000_0010,
    S_WALK   = 10'b00_0000_0100,
    S_DFREE1 = 10'b00_0000_1000,
    S_DFREE2 = 10'b00_0001_0000,
    S_IALLOC = 10'b00_0010_0000,
    S_ITAKE  = 10'b00_0100_0000,
    S_ILINK  = 10'b00_1000_0000,
    S_IHOOK  = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

endpackage

@@ src/cll_ctrl.sv @@
module cll_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  cll_pkg::stat_t st,
  output cll_pkg::cmd_t  cmd
);

  cll_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cll_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != cll_pkg::S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      cll_pkg::S_IDLE: begin
        if (start) begin
          cmd.cap   = 1'b1;
          state_nxt = cll_pkg::S_WSTART;
        end
      end
      cll_pkg::S_WSTART: begin
        cmd.rd_sel    = cll_pkg::A_ONE;
        cmd.walk_init = 1'b1;
        priority if (st.func == cll_pkg::F_NOP) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = cll_pkg::ST_OK;
          cmd.res_cell   = cll_pkg::C_NONE;
          state_nxt      = cll_pkg::S_DONE;
        end else if (st.func == cll_pkg::F_INS && st.pos_one) begin
          state_nxt = cll_pkg::S_IALLOC;
        end else if (st.func == cll_pkg::F_INS && st.pos_zero) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = cll_pkg::ST_BADPOS;
          cmd.res_cell   = cll_pkg::C_NONE;
          state_nxt      = cll_pkg::S_DONE;
        end else begin
          state_nxt = cll_pkg::S_WALK;
        end
      end
      cll_pkg::S_WALK: begin
        cmd.rd_sel = cll_pkg::A_CUR;
        priority if (st.cur_zero || st.walk_over) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = (st.func == cll_pkg::F_INS) ? cll_pkg::ST_BADPOS
                                                       : cll_pkg::ST_NOTFOUND;
          cmd.res_cell   = cll_pkg::C_NONE;
          state_nxt      = cll_pkg::S_DONE;
        end else if (st.func == cll_pkg::F_INS) begin
          if (st.cur_eq_pos) begin
            state_nxt = cll_pkg::S_IALLOC;
          end else begin
            cmd.walk_step = 1'b1;
          end
        end else if (st.val_match) begin
          if (st.func == cll_pkg::F_FIND) begin
            cmd.res_ld     = 1'b1;
            cmd.res_status = cll_pkg::ST_OK;
            cmd.res_cell   = cll_pkg::C_CUR;
            state_nxt      = cll_pkg::S_DONE;
          end else begin
            // unlink: prev skips over cur, cur's value cleared
            cmd.lw_en    = 1'b1;
            cmd.lw_addr  = cll_pkg::W_PREV;
            cmd.lw_data  = cll_pkg::D_RL;
            cmd.vw_en    = 1'b1;
            cmd.vw_clear = 1'b1;
            state_nxt    = cll_pkg::S_DFREE1;
          end
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      cll_pkg::S_DFREE1: begin
        cmd.rd_sel  = cll_pkg::A_ZERO;
        cmd.lw_en   = 1'b1;
        cmd.lw_addr = cll_pkg::W_CUR;
        cmd.lw_data = cll_pkg::D_RL;
        state_nxt   = cll_pkg::S_DFREE2;
      end
      cll_pkg::S_DFREE2: begin
        cmd.lw_en      = 1'b1;
        cmd.lw_addr    = cll_pkg::W_ZERO;
        cmd.lw_data    = cll_pkg::D_CUR;
        cmd.res_ld     = 1'b1;
        cmd.res_status = cll_pkg::ST_OK;
        cmd.res_cell   = cll_pkg::C_CUR;
        state_nxt      = cll_pkg::S_DONE;
      end
      cll_pkg::S_IALLOC: begin
        cmd.rd_sel    = cll_pkg::A_ZERO;
        cmd.free_load = 1'b1;
        if (st.rl_low) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = cll_pkg::ST_FULL;
          cmd.res_cell   = cll_pkg::C_NONE;
          state_nxt      = cll_pkg::S_DONE;
        end else begin
          state_nxt = cll_pkg::S_ITAKE;
        end
      end
      cll_pkg::S_ITAKE: begin
        cmd.rd_sel  = cll_pkg::A_FREE;
        cmd.lw_en   = 1'b1;
        cmd.lw_addr = cll_pkg::W_ZERO;
        cmd.lw_data = cll_pkg::D_RL;
        cmd.vw_en   = 1'b1;
        state_nxt   = cll_pkg::S_ILINK;
      end
      cll_pkg::S_ILINK: begin
        cmd.rd_sel  = cll_pkg::A_POS;
        cmd.lw_en   = 1'b1;
        cmd.lw_addr = cll_pkg::W_FREE;
        cmd.lw_data = cll_pkg::D_RL;
        state_nxt   = cll_pkg::S_IHOOK;
      end
      cll_pkg::S_IHOOK: begin
        cmd.lw_en      = 1'b1;
        cmd.lw_addr    = cll_pkg::W_POS;
        cmd.lw_data    = cll_pkg::D_FREE;
        cmd.res_ld     = 1'b1;
        cmd.res_status = cll_pkg::ST_OK;
        cmd.res_cell   = cll_pkg::C_FREE;
        state_nxt      = cll_pkg::S_DONE;
      end
      cll_pkg::S_DONE: begin
        cmd.rd_sel = cll_pkg::A_ONE;
        cmd.out_ld = 1'b1;
        state_nxt  = cll_pkg::S_IDLE;
      end
      default: begin
        state_nxt = cll_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ src/cll_dpath.sv @@
module cll_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [cll_pkg::FUNC_W-1:0]   in_func,
  input  logic signed [cll_pkg::VAL_W-1:0] in_value,
  input  logic [cll_pkg::POS_W-1:0]    in_position,
  input  cll_pkg::cmd_t                cmd,
  output cll_pkg::stat_t               st,
  output logic                         out_valid,
  output logic [cll_pkg::STAT_W-1:0]   out_status,
  output logic [cll_pkg::FC_W-1:0]     out_found_cell,
  output logic                         out_list_empty
);

  localparam int CW = cll_pkg::CELL_W;

  // cell pool: one read address and one link write a cycle
  logic [CW-1:0]               link_r  [cll_pkg::POOL_CELLS];
  logic [cll_pkg::VAL_W-1:0]   value_r [cll_pkg::POOL_CELLS];

  cll_pkg::func_t              func_r;
  logic [cll_pkg::VAL_W-1:0]   val_r;
  logic [cll_pkg::PW-1:0]      pos_r;
  logic [CW-1:0]               cur_r, prev_r, free_r;
  logic [cll_pkg::CNT_W-1:0]   cnt_r;
  cll_pkg::status_t            res_status_r;
  logic [CW-1:0]               res_cell_r;
  logic                        out_valid_r;
  logic [cll_pkg::STAT_W-1:0]  out_status_r;
  logic [cll_pkg::FC_W-1:0]    out_cell_r;
  logic                        out_empty_r;

  logic [CW-1:0]               rd_addr, wr_addr, wr_data, rl;
  logic [cll_pkg::VAL_W-1:0]   rv;
  logic [CW-1:0]               pos_cell;

  assign pos_cell = pos_r[CW-1:0];

  always_comb begin
    unique case (cmd.rd_sel)
      cll_pkg::A_ZERO: rd_addr = '0;
      cll_pkg::A_ONE:  rd_addr = CW'(1);
      cll_pkg::A_CUR:  rd_addr = cur_r;
      cll_pkg::A_POS:  rd_addr = pos_cell;
      cll_pkg::A_FREE: rd_addr = free_r;
      default:         rd_addr = '0;
    endcase
    unique case (cmd.lw_addr)
      cll_pkg::W_PREV: wr_addr = prev_r;
      cll_pkg::W_CUR:  wr_addr = cur_r;
      cll_pkg::W_ZERO: wr_addr = '0;
      cll_pkg::W_POS:  wr_addr = pos_cell;
      cll_pkg::W_FREE: wr_addr = free_r;
      default:         wr_addr = '0;
    endcase
    unique case (cmd.lw_data)
      cll_pkg::D_RL:   wr_data = rl;
      cll_pkg::D_CUR:  wr_data = cur_r;
      cll_pkg::D_FREE: wr_data = free_r;
      default:         wr_data = rl;
    endcase
  end

  assign rl = link_r[rd_addr];
  assign rv = value_r[rd_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // free chain 0 -> 2 -> ... -> last -> 0, header empty
      for (int i = 0; i < cll_pkg::POOL_CELLS; i++) begin
        value_r[i] <= '0;
        if (i == 0) begin
          link_r[i] <= CW'(2);
        end else if (i == 1 || i + 1 >= cll_pkg::POOL_CELLS) begin
          link_r[i] <= '0;
        end else begin
          link_r[i] <= CW'(i + 1);
        end
      end
    end else begin
      if (cmd.lw_en) begin
        link_r[wr_addr] <= wr_data;
      end
      if (cmd.vw_en) begin
        value_r[rd_addr] <= cmd.vw_clear ? '0 : val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cap) begin
        cnt_r <= '0;
      end else if (cmd.walk_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      out_valid_r <= cmd.out_ld;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      func_r <= cll_pkg::func_t'(in_func);
      val_r  <= in_value;
      pos_r  <= cll_pkg::PW'(in_position);
    end
    if (cmd.walk_init) begin
      cur_r  <= rl;
      prev_r <= CW'(1);
    end else if (cmd.walk_step) begin
      cur_r  <= rl;
      prev_r <= cur_r;
    end
    if (cmd.free_load) begin
      free_r <= rl;
    end
    if (cmd.res_ld) begin
      res_status_r <= cmd.res_status;
      unique case (cmd.res_cell)
        cll_pkg::C_NONE: res_cell_r <= '0;
        cll_pkg::C_CUR:  res_cell_r <= cur_r;
        cll_pkg::C_FREE: res_cell_r <= free_r;
        default:         res_cell_r <= '0;
      endcase
    end
    if (cmd.out_ld) begin
      out_status_r <= res_status_r;
      out_cell_r   <= cll_pkg::FC_W'(res_cell_r);
      out_empty_r  <= (rl == '0);
    end
  end

  always_comb begin
    st.func       = func_r;
    st.pos_zero   = (pos_r == '0);
    st.pos_one    = (pos_r == cll_pkg::PW'(1));
    st.cur_zero   = (cur_r == '0);
    st.cur_eq_pos = (cll_pkg::PW'(cur_r) == pos_r);
    st.val_match  = (rv == val_r);
    st.walk_over  = (cnt_r == cll_pkg::CNT_W'(cll_pkg::POOL_CELLS));
    st.rl_low     = (rl == '0) || (rl == CW'(1));
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found_cell = out_cell_r;
  assign out_list_empty = out_empty_r;

endmodule

@@ src/cursor_linked_list_engine.sv @@
// Channel   Ports                                      Handshake
// request   in_func, in_value, in_position             start & !busy
// result    out_status, out_found_cell, out_list_empty out_valid, one cycle
//
// Path of a request: IDLE captures it, WSTART reads the header, DONE loads the result.
//   NOP and insert at cell 0 go straight to DONE; find / delete walk the list in WALK,
//   a hitting delete adding DFREE1, DFREE2; insert after cell p > 1 walks to p (bad position
//   if not met), then takes a cell in IALLOC (full pool ends here), ITAKE, ILINK, IHOOK.
// The pool's single read port follows one link per cycle, up to POOL_CELLS links.
// Reset: synchronous, active low; the free chain loads in the reset cycle itself.
// busy stays high until the result strobe; the receiver cannot stall.
module cursor_linked_list_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [cll_pkg::FUNC_W-1:0]       in_func,
  input  logic signed [cll_pkg::VAL_W-1:0] in_value,
  input  logic [cll_pkg::POS_W-1:0]        in_position,
  output logic                             out_valid,
  output logic [cll_pkg::STAT_W-1:0]       out_status,
  output logic [cll_pkg::FC_W-1:0]         out_found_cell,
  output logic                             out_list_empty
);

  // command bundle from the sequencer, status bundle back from the pool
  cll_pkg::cmd_t  cmd;
  cll_pkg::stat_t st;

  // sequencer: one state per pool access of insert, delete, find
  cll_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // cell pool, cursor registers, compares and result registers
  cll_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_func        (in_func),
    .in_value       (in_value),
    .in_position    (in_position),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_found_cell (out_found_cell),
    .out_list_empty (out_list_empty)
  );

endmodule

@@ src/cll_checker.sv @@
module cll_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic [cll_pkg::FUNC_W-1:0]       in_func,
  input logic signed [cll_pkg::VAL_W-1:0] in_value,
  input logic [cll_pkg::POS_W-1:0]        in_position,
  input logic                             out_valid,
  input logic [cll_pkg::STAT_W-1:0]       out_status,
  input logic [cll_pkg::FC_W-1:0]         out_found_cell,
  input logic                             out_list_empty
);

  // accepted request keeps the engine busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low after accepted request");

  // request fields are known when taken
  a_req_known: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> !$isunknown({in_func, in_value, in_position}))
    else $error("unknown request field at acceptance");

  // result strobe lasts one cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // result comes as the engine goes idle
  a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside request end");

  // failed request reports no cell and a known list-empty flag
  a_fail_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != cll_pkg::ST_OK) |-> out_found_cell == '0 && !$isunknown(out_list_empty))
    else $error("cell reported on failed request");

endmodule

bind cursor_linked_list_engine cll_checker u_cll_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_func        (in_func),
  .in_value       (in_value),
  .in_position    (in_position),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_found_cell (out_found_cell),
  .out_list_empty (out_list_empty)
);
